FILE: hdl/cac_pkg.sv
// Types, command and status codes, and fixed-point helpers for the complex
// accumulator calculator. Depends on nothing; used by the top level and the testbench.
package cac_pkg;

  localparam int DATA_W    = 32;
  localparam int FRAC_BITS = 16;
  localparam int PROD_W    = 2 * DATA_W;
  localparam int ACC_W     = 2 * DATA_W + 2;
  localparam int DEN_W     = 2 * DATA_W;
  localparam int QUOT_W    = ACC_W + FRAC_BITS;

  localparam logic [2:0] CMD_OPERAND = 3'd0;
  localparam logic [2:0] OP_ADD      = 3'd1;
  localparam logic [2:0] OP_SUB      = 3'd2;
  localparam logic [2:0] OP_MUL      = 3'd3;
  localparam logic [2:0] OP_DIV      = 3'd4;
  localparam logic [2:0] OP_ASSIGN   = 3'd5;
  localparam logic [2:0] CMD_NOP     = 3'd6;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_TURN     = 2'd1;
  localparam logic [1:0] ST_DIV_ZERO = 2'd2;

  typedef struct packed {
    logic [2:0]               command;
    logic signed [DATA_W-1:0] operand_real;
    logic signed [DATA_W-1:0] operand_imag;
  } cmd_beat_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] acc_real;
    logic signed [DATA_W-1:0] acc_imag;
    logic [1:0]               status;
  } res_beat_t;

  // Clamp a sign and magnitude to the signed DATA_W range.
  function automatic logic [DATA_W-1:0] saturate(input logic neg,
                                                 input logic [QUOT_W-1:0] mag);
    logic [DATA_W-1:0] low;
    low = mag[DATA_W-1:0];
    if (|mag[QUOT_W-1:DATA_W-1]) begin
      return neg ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
    end
    return neg ? (~low + 1'b1) : low;
  endfunction

  function automatic logic [ACC_W-1:0] magnitude(input logic [ACC_W-1:0] v);
    return v[ACC_W-1] ? (~v + 1'b1) : v;
  endfunction

  function automatic logic [ACC_W-1:0] sext(input logic [DATA_W-1:0] v);
    return {{(ACC_W-DATA_W){v[DATA_W-1]}}, v};
  endfunction

endpackage

FILE: hdl/cac_div.sv
// Restoring bit-serial unsigned divider, one quotient bit per cycle.
// Depends on nothing; instanced by the calculator top level.
module cac_div #(
  parameter int NUM_W = 82,
  parameter int DEN_W = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quot
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] divisor;
  logic [NUM_W-1:0] shreg;
  logic [CNT_W-1:0] count;
  logic             busy;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             fits;

  assign trial = {rem, shreg[NUM_W-1]};
  assign diff  = trial - {1'b0, divisor};
  assign fits  = trial >= {1'b0, divisor};
  assign quot  = shreg;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy    <= 1'b1;
        count   <= CNT_W'(NUM_W);
        rem     <= '0;
        divisor <= den;
        shreg   <= num;
      end else if (busy) begin
        rem   <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        shreg <= {shreg[NUM_W-2:0], fits};
        count <= count - 1'b1;
        if (count == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  ast_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy)) else $error("divider done without a run");
  ast_no_restart: assert property (@(posedge clk) disable iff (rst)
    start |-> !busy) else $error("divider started while busy");
  ast_count_live: assert property (@(posedge clk) disable iff (rst)
    busy |-> count != '0) else $error("divider busy with zero count");

endmodule

FILE: hdl/complex_accumulator_calculator.sv
// Top level of the complex Q16.16 accumulator calculator: sequencer, shared
// multiplier and accumulator state. Depends on cac_pkg and cac_div.
//
//  Channel  Dir  Handshake          Beat payload
//  cmd      in   cmd_valid/stall    command, operand_real, operand_imag
//  res      out  res_valid/stall    acc_real, acc_imag, status
//
// Operators, no-ops, errors, add, subtract and assign pass through decode and output.
// Multiply sends six products through one 32x32 multiplier.
// Divide adds two 82-bit bit-serial divisions, the real quotient then the imaginary.
// Reset clears the accumulator to zero, selects assign and expects an operand.
// A stalled result waits in the output register while the next beat enters.
module complex_accumulator_calculator (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  output logic              cmd_stall,
  input  cac_pkg::cmd_beat_t cmd,
  output logic              res_valid,
  input  logic              res_stall,
  output cac_pkg::res_beat_t res
);

  localparam int DW = cac_pkg::DATA_W;
  localparam int AW = cac_pkg::ACC_W;
  localparam int QW = cac_pkg::QUOT_W;
  localparam logic [2:0] LAST_STEP = 3'd6;

  typedef enum logic [2:0] {
    S_IDLE, S_DECODE, S_MULT, S_DIV_RE, S_DIV_IM, S_OUT
  } state_t;

  state_t             state;
  cac_pkg::cmd_beat_t cmd_q;
  logic [DW-1:0]      accum_real;
  logic [DW-1:0]      accum_imag;
  logic [2:0]         pending_op;
  logic               expect_operator;
  logic [1:0]         status_q;

  // Product sequencer. Each step multiplies one pair; the next cycle adds
  // the registered product into the real, imaginary or denominator sum.
  logic [2:0]                       step;
  logic [2:0]                       prev;
  logic signed [DW-1:0]             mul_x;
  logic signed [DW-1:0]             mul_y;
  logic signed [cac_pkg::PROD_W-1:0] prod;
  logic [AW-1:0]                    term;
  logic [AW-1:0]                    sum_re;
  logic [AW-1:0]                    sum_im;
  logic [AW-1:0]                    sum_den;
  logic [QW-1:0]                    q_re;

  logic [AW-1:0] addsub_re;
  logic [AW-1:0] addsub_im;
  logic          div_start;
  logic [QW-1:0] div_num;
  logic [cac_pkg::DEN_W-1:0] div_den;
  logic          div_done;
  logic [QW-1:0] div_quot;
  logic          res_load;
  logic          is_mul;

  assign cmd_stall = (state != S_IDLE);
  assign prev      = step - 3'd1;
  assign term      = {{(AW-cac_pkg::PROD_W){prod[cac_pkg::PROD_W-1]}}, prod};
  assign is_mul    = (pending_op == cac_pkg::OP_MUL);
  assign res_load  = (state == S_OUT) && (!res_valid || !res_stall);

  always_comb begin
    case (step)
      3'd0:    begin mul_x = accum_real;        mul_y = cmd_q.operand_real; end
      3'd1:    begin mul_x = accum_imag;        mul_y = cmd_q.operand_imag; end
      3'd2:    begin mul_x = accum_real;        mul_y = cmd_q.operand_imag; end
      3'd3:    begin mul_x = accum_imag;        mul_y = cmd_q.operand_real; end
      3'd4:    begin mul_x = cmd_q.operand_real; mul_y = cmd_q.operand_real; end
      default: begin mul_x = cmd_q.operand_imag; mul_y = cmd_q.operand_imag; end
    endcase
  end

  // Add and subtract work part by part in a widened sum, then saturate.
  always_comb begin
    if (pending_op == cac_pkg::OP_SUB) begin
      addsub_re = cac_pkg::sext(accum_real) - cac_pkg::sext(cmd_q.operand_real);
      addsub_im = cac_pkg::sext(accum_imag) - cac_pkg::sext(cmd_q.operand_imag);
    end else begin
      addsub_re = cac_pkg::sext(accum_real) + cac_pkg::sext(cmd_q.operand_real);
      addsub_im = cac_pkg::sext(accum_imag) + cac_pkg::sext(cmd_q.operand_imag);
    end
  end

  // The real quotient starts at the end of the product steps, the imaginary
  // one as soon as the real one is done.
  assign div_start = ((state == S_MULT) && (step == LAST_STEP) && !is_mul) ||
                     ((state == S_DIV_RE) && div_done);
  assign div_num   = (state == S_MULT) ?
                     {cac_pkg::magnitude(sum_re), {cac_pkg::FRAC_BITS{1'b0}}} :
                     {cac_pkg::magnitude(sum_im), {cac_pkg::FRAC_BITS{1'b0}}};
  // On the last product step the final square is still in the product
  // register, so the first division takes the denominator with it folded in.
  assign div_den   = (state == S_MULT) ?
                     sum_den[cac_pkg::DEN_W-1:0] + term[cac_pkg::DEN_W-1:0] :
                     sum_den[cac_pkg::DEN_W-1:0];

  cac_div #(
    .NUM_W (QW),
    .DEN_W (cac_pkg::DEN_W)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      accum_real      <= '0;
      accum_imag      <= '0;
      pending_op      <= cac_pkg::OP_ASSIGN;
      expect_operator <= 1'b0;
      res_valid       <= 1'b0;
      step            <= '0;
    end else begin
      if (res_valid && !res_stall && !res_load) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            cmd_q <= cmd;
            state <= S_DECODE;
          end
        end
        S_DECODE: begin
          status_q <= cac_pkg::ST_OK;
          state    <= S_OUT;
          case (cmd_q.command)
            cac_pkg::CMD_OPERAND: begin
              if (expect_operator) begin
                status_q <= cac_pkg::ST_TURN;
              end else if (pending_op == cac_pkg::OP_ADD ||
                           pending_op == cac_pkg::OP_SUB) begin
                accum_real      <= cac_pkg::saturate(addsub_re[AW-1],
                                     QW'(cac_pkg::magnitude(addsub_re)));
                accum_imag      <= cac_pkg::saturate(addsub_im[AW-1],
                                     QW'(cac_pkg::magnitude(addsub_im)));
                expect_operator <= 1'b1;
              end else if (pending_op == cac_pkg::OP_MUL ||
                           pending_op == cac_pkg::OP_DIV) begin
                if (!is_mul && cmd_q.operand_real == '0 &&
                    cmd_q.operand_imag == '0) begin
                  status_q <= cac_pkg::ST_DIV_ZERO;
                end else begin
                  step    <= '0;
                  sum_re  <= '0;
                  sum_im  <= '0;
                  sum_den <= '0;
                  state   <= S_MULT;
                end
              end else begin
                accum_real      <= cmd_q.operand_real;
                accum_imag      <= cmd_q.operand_imag;
                expect_operator <= 1'b1;
              end
            end
            cac_pkg::OP_ADD, cac_pkg::OP_SUB, cac_pkg::OP_MUL,
            cac_pkg::OP_DIV, cac_pkg::OP_ASSIGN: begin
              if (!expect_operator) begin
                status_q <= cac_pkg::ST_TURN;
              end else begin
                pending_op      <= cmd_q.command;
                expect_operator <= 1'b0;
              end
            end
            cac_pkg::CMD_NOP: begin
              status_q <= cac_pkg::ST_OK;
            end
            default: begin
              status_q <= cac_pkg::ST_TURN;
            end
          endcase
        end
        S_MULT: begin
          if (step != LAST_STEP) begin
            prod <= mul_x * mul_y;
            step <= step + 3'd1;
          end
          if (step != 3'd0) begin
            case (prev)
              3'd0: sum_re <= sum_re + term;
              3'd1: sum_re <= is_mul ? sum_re - term : sum_re + term;
              3'd2: sum_im <= is_mul ? sum_im + term : sum_im - term;
              3'd3: sum_im <= sum_im + term;
              default: sum_den <= sum_den + term;
            endcase
          end
          if (step == LAST_STEP) begin
            if (is_mul) begin
              accum_real      <= cac_pkg::saturate(sum_re[AW-1],
                QW'(cac_pkg::magnitude(sum_re) >> cac_pkg::FRAC_BITS));
              accum_imag      <= cac_pkg::saturate(sum_im[AW-1],
                QW'(cac_pkg::magnitude(sum_im) >> cac_pkg::FRAC_BITS));
              expect_operator <= 1'b1;
              state           <= S_OUT;
            end else begin
              state <= S_DIV_RE;
            end
          end
        end
        S_DIV_RE: begin
          if (div_done) begin
            q_re  <= div_quot;
            state <= S_DIV_IM;
          end
        end
        S_DIV_IM: begin
          if (div_done) begin
            accum_real      <= cac_pkg::saturate(sum_re[AW-1], q_re);
            accum_imag      <= cac_pkg::saturate(sum_im[AW-1], div_quot);
            expect_operator <= 1'b1;
            state           <= S_OUT;
          end
        end
        S_OUT: begin
          if (res_load) begin
            res.acc_real <= accum_real;
            res.acc_imag <= accum_imag;
            res.status   <= status_q;
            res_valid    <= 1'b1;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  ast_div_only_for_divide: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV_RE || state == S_DIV_IM) |-> pending_op == cac_pkg::OP_DIV)
    else $error("division running without a pending divide");
  ast_div_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_DIV_RE || state == S_DIV_IM))
    else $error("quotient arrived outside a division wait");
  ast_result_is_accum: assert property (@(posedge clk) disable iff (rst)
    res_load |=> (res.acc_real == accum_real && res.acc_imag == accum_imag))
    else $error("result beat differs from accumulator");
  ast_operator_clear: assert property (@(posedge clk) disable iff (rst)
    $fell(expect_operator) |-> $past(state) == S_DECODE)
    else $error("turn flag cleared outside decode");

endmodule

FILE: dv/testbench.sv
// Self-checking testbench for the complex accumulator calculator.
// Depends on cac_pkg and the complex_accumulator_calculator RTL in hdl.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import cac_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      cmd_valid = 1'b0;
  logic      cmd_stall;
  cmd_beat_t cmd = '0;
  logic      res_valid;
  logic      res_stall = 1'b0;
  res_beat_t res;

  complex_accumulator_calculator DUT (
    .clk(clk), .rst(rst), .cmd_valid(cmd_valid), .cmd_stall(cmd_stall), .cmd(cmd),
    .res_valid(res_valid), .res_stall(res_stall), .res(res)
  );

  always #5 clk = ~clk;

  // Predictor state: accumulator, selected operator and turn flag.
  logic signed [31:0] calc_re, calc_im;
  logic [2:0]         calc_op;
  logic               calc_want_op;

  cmd_beat_t beats_to_send[$];
  res_beat_t expected_results[$];
  int        error_count = 0;
  bit        hold_results = 0;
  int        idle_cycles = 0;
  int        send_gap = 0;
  int        recv_gap = 0;

  task automatic report(input string what);
    error_count++;
    $display("ERROR @%0t: %s", $realtime, what);
  endtask

  // Clamp an exact signed value to 32 bits.
  function automatic logic [31:0] clamp32(input logic signed [127:0] v);
    if (v > 128'sd2147483647) return 32'h7fffffff;
    if (v < -128'sd2147483648) return 32'h80000000;
    return v[31:0];
  endfunction

  // Signed shift right by FRAC_BITS, truncated toward zero (SV '/' already truncates).
  function automatic logic signed [127:0] shr_trunc(input logic signed [127:0] v);
    logic signed [127:0] m;
    m = (v < 0) ? -v : v;
    m = m >>> FRAC_BITS;
    return (v < 0) ? -m : m;
  endfunction

  // Advance the accumulator by one beat and return the result it must produce.
  function automatic res_beat_t calc_step(input cmd_beat_t b);
    res_beat_t r;
    logic signed [127:0] ar, ai, br, bi, nr, ni, den;
    r.status = ST_OK;
    ar = calc_re; ai = calc_im; br = b.operand_real; bi = b.operand_imag;
    if (b.command == CMD_OPERAND) begin
      if (calc_want_op) begin
        r.status = ST_TURN;
      end else if (calc_op == OP_DIV && br == 0 && bi == 0) begin
        r.status = ST_DIV_ZERO;
      end else begin
        case (calc_op)
          OP_ADD: begin nr = ar + br; ni = ai + bi; end
          OP_SUB: begin nr = ar - br; ni = ai - bi; end
          OP_MUL: begin
            nr = shr_trunc(ar * br - ai * bi);
            ni = shr_trunc(ar * bi + ai * br);
          end
          OP_DIV: begin
            den = br * br + bi * bi;
            nr = ((ar * br + ai * bi) * (128'sd1 <<< FRAC_BITS)) / den;
            ni = ((ai * br - ar * bi) * (128'sd1 <<< FRAC_BITS)) / den;
          end
          default: begin nr = br; ni = bi; end
        endcase
        calc_re = clamp32(nr);
        calc_im = clamp32(ni);
        calc_want_op = 1'b1;
      end
    end else if (b.command >= OP_ADD && b.command <= OP_ASSIGN) begin
      if (!calc_want_op) begin
        r.status = ST_TURN;
      end else begin
        calc_op = b.command;
        calc_want_op = 1'b0;
      end
    end else if (b.command != CMD_NOP) begin
      r.status = ST_TURN;
    end
    r.acc_real = calc_re;
    r.acc_imag = calc_im;
    return r;
  endfunction

  function automatic int gap_len();
    if ($urandom_range(0, 2) == 0) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    return $urandom_range(0, 3);
  endfunction

  // Operand values biased toward the interesting corners.
  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return 32'h0;
      3: return 32'h00010000;
      4: return 32'hffff0000;
      5: return $urandom_range(0, 4) == 0 ? 32'h0 : {{12{1'b0}}, 20'($urandom)};
      6: return -$signed({12'h0, 20'($urandom)});
      default: return $urandom;
    endcase
  endfunction

  function automatic cmd_beat_t mk(input logic [2:0] c, input logic [31:0] re,
                                   input logic [31:0] im);
    cmd_beat_t b;
    b.command = c; b.operand_real = re; b.operand_imag = im;
    return b;
  endfunction

  // Driver: offers queued beats, holding the payload steady while stalled.
  always @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (cmd_valid && cmd_stall) begin
      // Beat is held until the block takes it.
    end else begin
      if (cmd_valid) begin
        expected_results.push_back(calc_step(cmd));
      end
      if (send_gap > 0) begin
        send_gap--;
        cmd_valid <= 1'b0;
      end else if (beats_to_send.size() > 0) begin
        cmd <= beats_to_send.pop_front();
        cmd_valid <= 1'b1;
        send_gap = gap_len();
      end else begin
        cmd_valid <= 1'b0;
      end
    end
  end

  // Monitor: checks each accepted result beat against the oldest prediction.
  always @(posedge clk) begin
    res_beat_t want;
    if (!rst) begin
      if (res_valid && !res_stall) begin
        idle_cycles = 0;
        if (expected_results.size() == 0) begin
          report($sformatf("unexpected result beat %h", res));
        end else begin
          want = expected_results.pop_front();
          if (res.acc_real !== want.acc_real)
            report($sformatf("acc_real %h, expected %h", res.acc_real, want.acc_real));
          if (res.acc_imag !== want.acc_imag)
            report($sformatf("acc_imag %h, expected %h", res.acc_imag, want.acc_imag));
          if (res.status !== want.status)
            report($sformatf("status %0d, expected %0d", res.status, want.status));
        end
      end else if (cmd_valid && !cmd_stall) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("complex_accumulator_calculator regression: fail");
        $finish;
      end
      // Receiver back-pressure: random gaps, or a long hold when requested.
      if (hold_results) begin
        res_stall <= 1'b1;
      end else if (recv_gap > 0) begin
        recv_gap--;
        res_stall <= 1'b1;
      end else begin
        res_stall <= 1'b0;
        recv_gap = gap_len();
      end
    end
  end

  // Well-formed sequence: operand, then random operator/operand pairs.
  task automatic add_chain(input int pairs);
    logic [2:0] op;
    beats_to_send.push_back(mk(CMD_OPERAND, pick_value(), pick_value()));
    repeat (pairs) begin
      op = 3'($urandom_range(1, 5));
      // Keep slow division a minority of the operators.
      if (op == OP_DIV && $urandom_range(0, 2) != 0) op = OP_MUL;
      beats_to_send.push_back(mk(op, $urandom, $urandom));
      beats_to_send.push_back(mk(CMD_OPERAND, pick_value(), pick_value()));
    end
  endtask

  task automatic wait_drained();
    while (beats_to_send.size() > 0 || cmd_valid || expected_results.size() > 0)
      @(posedge clk);
  endtask

  initial begin
    int count;
    int queued;
    calc_re = '0; calc_im = '0; calc_op = OP_ASSIGN; calc_want_op = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed part: turn errors, every operator, extremes, division by zero.
    beats_to_send.push_back(mk(OP_ADD, '0, '0));             // operator out of turn
    beats_to_send.push_back(mk(3'd7, '1, '1));                // invalid code
    beats_to_send.push_back(mk(CMD_NOP, '1, '1));
    beats_to_send.push_back(mk(CMD_OPERAND, 32'h7fffffff, 32'h80000000));
    beats_to_send.push_back(mk(CMD_OPERAND, '0, '0));         // operand out of turn
    beats_to_send.push_back(mk(OP_ADD, '0, '0));
    beats_to_send.push_back(mk(CMD_OPERAND, 32'h7fffffff, 32'h80000000)); // saturates
    beats_to_send.push_back(mk(OP_SUB, '0, '0));
    beats_to_send.push_back(mk(CMD_OPERAND, 32'h80000000, 32'h7fffffff));
    beats_to_send.push_back(mk(OP_MUL, '0, '0));
    beats_to_send.push_back(mk(CMD_OPERAND, 32'h80000000, 32'h80000000));
    beats_to_send.push_back(mk(OP_DIV, '0, '0));
    beats_to_send.push_back(mk(CMD_OPERAND, '0, '0));         // division by zero
    beats_to_send.push_back(mk(CMD_OPERAND, 32'h00000001, 32'hffffffff));
    beats_to_send.push_back(mk(OP_ASSIGN, '0, '0));
    beats_to_send.push_back(mk(CMD_OPERAND, 32'hfffe8000, 32'h00018000));
    beats_to_send.push_back(mk(OP_MUL, '0, '0));
    beats_to_send.push_back(mk(CMD_OPERAND, 32'hffffffff, 32'h00000001));
    beats_to_send.push_back(mk(OP_DIV, '0, '0));
    beats_to_send.push_back(mk(CMD_OPERAND, 32'h00000000, 32'h00000001));
    beats_to_send.push_back(mk(CMD_NOP, '0, '0));

    // Long receiver hold while the sender keeps offering beats.
    add_chain(8);
    hold_results = 1;
    repeat (300) @(posedge clk);
    hold_results = 0;
    wait_drained();   // sender pause until every result is in

    count = 0;
    while (count < 1850) begin
      queued = beats_to_send.size();
      if ($urandom_range(0, 9) < 8) begin
        add_chain($urandom_range(1, 12));
      end else begin
        repeat ($urandom_range(1, 4))
          beats_to_send.push_back(mk(3'($urandom_range(0, 7)), pick_value(), pick_value()));
      end
      count = count + beats_to_send.size() - queued;
      while (beats_to_send.size() > 4) @(posedge clk);
      if ($urandom_range(0, 40) == 0) wait_drained();
    end
    wait_drained();
    repeat (400) @(posedge clk);
    if (error_count == 0) begin
      $display("complex_accumulator_calculator regression: pass");
    end else begin
      $display("complex_accumulator_calculator regression: fail");
    end
    $finish;
  end
endmodule

FILE: files.f
hdl/cac_pkg.sv
hdl/cac_div.sv
hdl/complex_accumulator_calculator.sv
dv/testbench.sv
